>>> src/ott_pkg.sv
package ott_pkg;

  localparam logic [31:0] DEFAULT_WINDOW = 32'd3600000;
  localparam logic [63:0] NO_TIMER = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_CANCEL  = 3'd1;
  localparam logic [2:0] OP_REFRESH = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_NEXT    = 3'd4;
  localparam logic [2:0] OP_SWEEP   = 3'd5;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic        recurring;
    logic        restart_now;
    logic [63:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_id;
    logic [63:0] delay_ms;
    logic        expired_valid;
    logic        last;
    logic        wake_request;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // latch command
    logic scan_clr;  // reset scan accumulators
    logic scan_step; // evaluate one slot
    logic keep_due;  // rescan: pick among marked due slots only
    logic apply;     // perform single-result command
    logic emit_pick; // pop best due slot
    logic emit_none; // single sweep result, nothing due
  } ott_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_done;
    logic any_due;
    logic more_due;
  } ott_stat_t;

endpackage

>>> src/ott_datapath.sv
module ott_datapath #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ott_pkg::in_item_t   in_data,
  input  logic [31:0]         window,
  input  ott_pkg::ott_cmd_t   cmd,
  output ott_pkg::ott_stat_t  stat,
  output ott_pkg::out_item_t  res
);
  localparam int IW = $clog2(NUM_SLOTS);

  ott_pkg::in_item_t cmd_r;
  logic [63:0] dl_r [NUM_SLOTS];
  logic [31:0] per_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] act_r, rec_r, due_r;
  logic [63:0] last_seen_r;
  logic wake_r, roll_r;
  logic [IW:0] idx_r;
  logic [IW-1:0] best_r, free_r;
  logic best_v_r, free_v_r;

  logic [IW-1:0] idx;
  logic [IW-1:0] s;
  logic inrange, is_sweep, shortcut, cand;
  logic [63:0] start, newdl, add_dl;
  logic dueck, better;
  ott_pkg::out_item_t res_nxt;

  assign idx = idx_r[IW-1:0];
  assign inrange = ({28'd0, cmd_r.slot} < 32'(NUM_SLOTS));
  assign s = inrange ? IW'(cmd_r.slot) : '0;
  assign stat.scan_done = (idx_r == (IW+1)'(NUM_SLOTS));
  assign stat.any_due = |due_r;
  assign stat.more_due = $countones(due_r) > 1;

  // scan step: due mark for sweep, earliest among candidates
  always_comb begin
    is_sweep = (cmd_r.opcode == ott_pkg::OP_SWEEP);
    dueck = act_r[idx] && (roll_r || dl_r[idx] <= cmd_r.now_ms);
    if (cmd.keep_due) cand = due_r[idx];
    else if (is_sweep) cand = dueck;
    // reset compares its new deadline against the other slots only
    else cand = act_r[idx] && !(cmd_r.opcode == ott_pkg::OP_RESET && idx == s);
    better = !best_v_r || dl_r[idx] < dl_r[best_r];
    shortcut = (cmd_r.period_ms == per_r[s]) && !cmd_r.restart_now;
    start = cmd_r.restart_now ? cmd_r.now_ms : dl_r[s] - 64'(per_r[s]);
    newdl = start + 64'(cmd_r.period_ms);
    add_dl = cmd_r.now_ms + 64'(cmd_r.period_ms);
  end

  // result of the current apply or emit step
  always_comb begin
    res_nxt = '0;
    res_nxt.last = 1'b1;
    if (cmd.emit_pick) begin
      res_nxt.slot_id = 4'(best_r);
      res_nxt.expired_valid = 1'b1;
      res_nxt.last = !stat.more_due;
    end else if (cmd.apply) begin
      case (cmd_r.opcode)
        ott_pkg::OP_ADD: begin
          if (!free_v_r) res_nxt.status = ott_pkg::ST_FULL;
          else begin
            res_nxt.slot_id = 4'(free_r);
            // new earliest: strictly before current best, or ties at lower index
            if (!wake_r && (!best_v_r || add_dl < dl_r[best_r] ||
                (add_dl == dl_r[best_r] && free_r < best_r)))
              res_nxt.wake_request = 1'b1;
          end
        end
        ott_pkg::OP_CANCEL, ott_pkg::OP_REFRESH: begin
          if (!inrange || !act_r[s]) res_nxt.status = ott_pkg::ST_INACTIVE;
        end
        ott_pkg::OP_RESET: begin
          if (!inrange || (!shortcut && !act_r[s]))
            res_nxt.status = ott_pkg::ST_INACTIVE;
          else if (!shortcut && !wake_r && (!best_v_r || newdl < dl_r[best_r] ||
                   (newdl == dl_r[best_r] && s < best_r)))
            res_nxt.wake_request = 1'b1;
        end
        ott_pkg::OP_NEXT: begin
          if (!best_v_r) res_nxt.delay_ms = ott_pkg::NO_TIMER;
          else if (cmd_r.now_ms >= dl_r[best_r]) res_nxt.delay_ms = '0;
          else res_nxt.delay_ms = dl_r[best_r] - cmd_r.now_ms;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0; rec_r <= '0; last_seen_r <= '0; wake_r <= 1'b0;
      idx_r <= '0; best_v_r <= 1'b0; free_v_r <= 1'b0; due_r <= '0;
      roll_r <= 1'b0; res <= '0;
    end else begin
      if (cmd.load) begin
        cmd_r <= in_data;
      end
      if (cmd.scan_clr) begin
        idx_r <= '0; best_v_r <= 1'b0; free_v_r <= 1'b0; due_r <= '0;
        roll_r <= (in_data.now_ms < last_seen_r) &&
                  ((last_seen_r - in_data.now_ms) > 64'(window));
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (cand && better) begin
          best_r <= idx; best_v_r <= 1'b1;
        end
        if (!act_r[idx] && !free_v_r) begin
          free_r <= idx; free_v_r <= 1'b1;
        end
        if (!cmd.keep_due) due_r[idx] <= dueck && is_sweep;
      end
      if (cmd.apply || cmd.emit_pick || cmd.emit_none) begin
        res <= res_nxt;
      end
      if (cmd.apply) begin
        if (res_nxt.wake_request) wake_r <= 1'b1;
        else if (cmd_r.opcode == ott_pkg::OP_NEXT) wake_r <= 1'b0;
        case (cmd_r.opcode)
          ott_pkg::OP_ADD: begin
            if (free_v_r) begin
              act_r[free_r] <= 1'b1;
              rec_r[free_r] <= cmd_r.recurring;
              per_r[free_r] <= cmd_r.period_ms;
              dl_r[free_r] <= add_dl;
            end
          end
          ott_pkg::OP_CANCEL: begin
            if (inrange && act_r[s]) act_r[s] <= 1'b0;
          end
          ott_pkg::OP_REFRESH: begin
            if (inrange && act_r[s]) dl_r[s] <= cmd_r.now_ms + 64'(per_r[s]);
          end
          ott_pkg::OP_RESET: begin
            if (inrange && !shortcut && act_r[s]) begin
              per_r[s] <= cmd_r.period_ms;
              dl_r[s] <= newdl;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.emit_pick) begin
        due_r[best_r] <= 1'b0;
        if (rec_r[best_r]) dl_r[best_r] <= cmd_r.now_ms + 64'(per_r[best_r]);
        else act_r[best_r] <= 1'b0;
        last_seen_r <= cmd_r.now_ms;
      end
      // a sweep of a non-empty table records the time even when nothing is due
      if (cmd.emit_none && |act_r) last_seen_r <= cmd_r.now_ms;
      if (cmd.emit_pick || cmd.emit_none) begin
        idx_r <= '0; best_v_r <= 1'b0;
      end
    end
  end
endmodule

>>> src/ott_ctrl.sv
module ott_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         opcode,
  input  ott_pkg::ott_stat_t stat,
  output ott_pkg::ott_cmd_t  cmd,
  output logic               busy,
  output logic               res_strobe
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_PICK, S_RESCAN, S_OUT} state_t;
  state_t state_r;
  logic is_sweep_r;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state_r == S_IDLE) && start;
    cmd.scan_clr = cmd.load;
    cmd.scan_step = (state_r == S_SCAN || state_r == S_RESCAN) && !stat.scan_done;
    cmd.keep_due = (state_r == S_RESCAN);
    cmd.apply = (state_r == S_APPLY) && !is_sweep_r;
    cmd.emit_none = (state_r == S_APPLY) && is_sweep_r && !stat.any_due;
    cmd.emit_pick = (state_r == S_PICK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; res_strobe <= 1'b0; is_sweep_r <= 1'b0;
    end else begin
      res_strobe <= cmd.apply || cmd.emit_none || cmd.emit_pick;
      case (state_r)
        S_IDLE: if (start) begin
          is_sweep_r <= (opcode == ott_pkg::OP_SWEEP);
          state_r <= S_SCAN;
        end
        S_SCAN: if (stat.scan_done) state_r <= S_APPLY;
        S_APPLY: begin
          if (is_sweep_r && stat.any_due) state_r <= S_PICK;
          else state_r <= S_OUT;
        end
        S_PICK: state_r <= stat.more_due ? S_RESCAN : S_OUT;
        S_RESCAN: if (stat.scan_done) state_r <= S_PICK;
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/ordered_timer_table_core.sv
// Ordered timer table. A command is taken when start is high and busy low;
// its results appear on out_data, one per out_valid pulse, and cannot be
// stalled. Every command walks all NUM_SLOTS slots one per cycle, and a
// single-result command holds busy until its result is out; the next
// command can be taken as soon as busy drops. A sweep that expires k
// timers emits them one at a time, with one slot rescan per further
// timer to find the next in deadline/slot order. Rollover window is
// written through cfg_valid/cfg_ready; ready only while idle.
module ordered_timer_table_core #(
  parameter int NUM_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ott_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ott_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  ott_pkg::ott_cmd_t cmd;
  ott_pkg::ott_stat_t stat;
  logic [31:0] window_r;

  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) window_r <= ott_pkg::DEFAULT_WINDOW;
    else if (cfg_valid && cfg_ready) window_r <= cfg_data;
  end

  // scan for the reset command skips its own slot when comparing for wake
  ott_ctrl u_ctrl (.clk, .rst_n, .start, .opcode(in_data.opcode), .stat, .cmd,
                   .busy, .res_strobe(out_valid));

  ott_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (.clk, .rst_n, .in_data,
    .window(window_r), .cmd, .stat, .res(out_data));

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid || $past(busy)) else $error("stray result");
endmodule

>>> dv/ott_checker.sv
module ott_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  ott_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  ott_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;

  logic [63:0] dl [SLOTS];
  logic [31:0] per [SLOTS];
  logic        act [SLOTS];
  logic        rec [SLOTS];
  logic [63:0] seen;
  logic        wake;
  logic [31:0] window;
  ott_pkg::out_item_t exp_results [$];

  assign pending = exp_results.size();

  function automatic bit ahead(int a, int b);
    if (dl[a] != dl[b]) return dl[a] < dl[b];
    return a < b;
  endfunction

  function automatic int first_timer();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (act[i] && (best < 0 || ahead(i, best))) best = i;
    return best;
  endfunction

  function automatic logic wake_rule(int s);
    if (first_timer() == s && !wake) begin
      wake = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push(logic [1:0] st, int id, logic [63:0] d, logic v, logic l, logic w);
    ott_pkg::out_item_t r;
    r.status = st;
    r.slot_id = id[3:0];
    r.delay_ms = d;
    r.expired_valid = v;
    r.last = l;
    r.wake_request = w;
    exp_results.insert(exp_results.size(), r);
  endtask

  task automatic predict(ott_pkg::in_item_t c);
    int s, f, e, n, best;
    logic [63:0] st;
    bit roll;
    bit due [SLOTS];
    s = int'(c.slot);
    case (c.opcode)
      ott_pkg::OP_ADD: begin
        f = -1;
        for (int i = 0; i < SLOTS && f < 0; i++) if (!act[i]) f = i;
        if (f < 0) push(ott_pkg::ST_FULL, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        else begin
          act[f] = 1'b1; rec[f] = c.recurring; per[f] = c.period_ms;
          dl[f] = c.now_ms + 64'(c.period_ms);
          push(ott_pkg::ST_OK, f, 64'd0, 1'b0, 1'b1, wake_rule(f));
        end
      end
      ott_pkg::OP_CANCEL: begin
        if (!act[s]) push(ott_pkg::ST_INACTIVE, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        else begin
          act[s] = 1'b0;
          push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      ott_pkg::OP_REFRESH: begin
        if (!act[s]) push(ott_pkg::ST_INACTIVE, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        else begin
          dl[s] = c.now_ms + 64'(per[s]);
          push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      ott_pkg::OP_RESET: begin
        if (c.period_ms == per[s] && !c.restart_now)
          push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        else if (!act[s]) push(ott_pkg::ST_INACTIVE, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        else begin
          st = c.restart_now ? c.now_ms : dl[s] - 64'(per[s]);
          per[s] = c.period_ms;
          dl[s] = st + 64'(c.period_ms);
          push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, wake_rule(s));
        end
      end
      ott_pkg::OP_NEXT: begin
        e = first_timer();
        wake = 1'b0;
        if (e < 0) push(ott_pkg::ST_OK, 0, ott_pkg::NO_TIMER, 1'b0, 1'b1, 1'b0);
        else if (c.now_ms >= dl[e]) push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        else push(ott_pkg::ST_OK, 0, dl[e] - c.now_ms, 1'b0, 1'b1, 1'b0);
      end
      ott_pkg::OP_SWEEP: begin
        if (first_timer() < 0) push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, 1'b0);
        else begin
          roll = c.now_ms < seen && (seen - c.now_ms) > 64'(window);
          seen = c.now_ms;
          n = 0;
          for (int i = 0; i < SLOTS; i++) begin
            due[i] = act[i] && (roll || dl[i] <= c.now_ms);
            if (due[i]) n++;
          end
          if (n == 0) push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, 1'b0);
          for (int k = 0; k < n; k++) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
              if (due[i] && (best < 0 || ahead(i, best))) best = i;
            due[best] = 0;
            push(ott_pkg::ST_OK, best, 64'd0, 1'b1, k == n - 1, 1'b0);
            if (rec[best]) dl[best] = c.now_ms + 64'(per[best]);
            else act[best] = 1'b0;
          end
        end
      end
      default: push(ott_pkg::ST_OK, 0, 64'd0, 1'b0, 1'b1, 1'b0);
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        act[i] = 1'b0; rec[i] = 1'b0; per[i] = '0; dl[i] = '0;
      end
      seen = '0;
      wake = 1'b0;
      window = ott_pkg::DEFAULT_WINDOW;
      fail_count <= 0;
      exp_results.delete();
    end else begin
      if (out_valid) begin
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else if (exp_results[0] !== out_data) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_results[0], out_data);
          fail_count <= fail_count + 1;
          void'(exp_results.pop_front());
        end else void'(exp_results.pop_front());
      end
      if (cfg_valid && cfg_ready) window = cfg_data;
      if (start && !busy) predict(in_data);
    end
  end
endmodule

>>> dv/tb_ordered_timer_table_core.sv
module tb_ordered_timer_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  ott_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  ott_pkg::out_item_t out_data;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 idle_pct = 0;   // sender gap odds, per hundred
  logic [63:0]        clock_ms = 0;   // running notion of "now"

  localparam int CYCLE_LIMIT = 1_500_000;

  always #2 clk = ~clk;

  ordered_timer_table_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ott_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one command transaction; start stays up across back-to-back commands
  task automatic issue(ott_pkg::in_item_t c);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cmd(logic [2:0] op, int s, logic [31:0] p, logic r, logic fn,
                     logic [63:0] t);
    ott_pkg::in_item_t c;
    c.opcode = op; c.slot = s[3:0]; c.period_ms = p;
    c.recurring = r; c.restart_now = fn; c.now_ms = t;
    issue(c);
  endtask

  // quiesce: wait out all results plus one full scan before a config write
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_window(logic [31:0] w);
    drain();
    cfg_valid <= 1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_cmd();
    int k;
    logic [31:0] p;
    logic [63:0] t;
    k = $urandom_range(99);
    p = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(200));
    // mostly creep forward; sometimes jump far back or to random extremes
    if ($urandom_range(19) == 0) t = {$urandom, $urandom};
    else if ($urandom_range(14) == 0) t = clock_ms - 64'($urandom_range(8000000));
    else t = clock_ms + 64'($urandom_range(60));
    clock_ms = t;
    if (k < 30) cmd(ott_pkg::OP_ADD, 0, p, 1'($urandom_range(1)), 1'b0, t);
    else if (k < 40) cmd(ott_pkg::OP_CANCEL, $urandom_range(15), p, 1'b0, 1'b0, t);
    else if (k < 50) cmd(ott_pkg::OP_REFRESH, $urandom_range(15), p, 1'b0, 1'b0, t);
    else if (k < 62)
      cmd(ott_pkg::OP_RESET, $urandom_range(15), p, 1'b0, 1'($urandom_range(1)), t);
    else if (k < 74) cmd(ott_pkg::OP_NEXT, 0, p, 1'b0, 1'b0, t);
    else if (k < 97) cmd(ott_pkg::OP_SWEEP, 0, p, 1'b0, 1'b0, t);
    else cmd($urandom_range(1) ? ott_pkg::OP_SPARE_A : ott_pkg::OP_SPARE_B,
             $urandom_range(15), $urandom, 1'b1, 1'b1, t);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, all opcodes, field extremes; the fill below
    // writes every slot's period before any random reset can read it
    cmd(ott_pkg::OP_NEXT, 0, 32'd0, 1'b0, 1'b0, 64'd0);
    cmd(ott_pkg::OP_SWEEP, 0, 32'd0, 1'b0, 1'b0, 64'd100);
    cmd(ott_pkg::OP_CANCEL, 15, 32'd0, 1'b0, 1'b0, 64'd0);
    cmd(ott_pkg::OP_ADD, 0, 32'd50, 1'b0, 1'b0, 64'd100);
    cmd(ott_pkg::OP_ADD, 0, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    cmd(ott_pkg::OP_ADD, 0, 32'd50, 1'b1, 1'b0, 64'd100);  // deadline tie with slot 0
    cmd(ott_pkg::OP_NEXT, 0, 32'd0, 1'b0, 1'b0, 64'd120);
    cmd(ott_pkg::OP_ADD, 0, 32'd10, 1'b0, 1'b0, 64'd100);  // new earliest after next-delay
    cmd(ott_pkg::OP_RESET, 3, 32'd10, 1'b0, 1'b0, 64'd0);  // equal period shortcut
    cmd(ott_pkg::OP_RESET, 3, 32'd30, 1'b0, 1'b0, 64'd0);  // from old start
    cmd(ott_pkg::OP_RESET, 2, 32'd5, 1'b1, 1'b1, 64'd101);
    cmd(ott_pkg::OP_REFRESH, 0, 32'd0, 1'b0, 1'b0, 64'd105);
    cmd(ott_pkg::OP_REFRESH, 9, 32'd0, 1'b0, 1'b0, 64'd105);
    cmd(ott_pkg::OP_NEXT, 0, 32'd0, 1'b0, 1'b0, 64'd200);
    cmd(ott_pkg::OP_SWEEP, 0, 32'd0, 1'b0, 1'b0, 64'd160);
    cmd(ott_pkg::OP_SPARE_A, 5, 32'hFFFF_FFFF, 1'b1, 1'b1, '1);
    cmd(ott_pkg::OP_SPARE_B, 0, 32'd0, 1'b0, 1'b0, 64'd0);
    for (int i = 0; i < 15; i++) cmd(ott_pkg::OP_ADD, 0, 32'd1000, 1'b0, 1'b0, 64'd200);
    cmd(ott_pkg::OP_SWEEP, 0, 32'd0, 1'b0, 1'b0, 64'd10);  // no rollover, nothing due
    set_window(32'd0);
    cmd(ott_pkg::OP_SWEEP, 0, 32'd0, 1'b0, 1'b0, 64'd9);   // one ms back: rollover
    set_window(32'hFFFF_FFFF);
    clock_ms = 64'd5000;

    // random phases with different sender idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 87;
        default: idle_pct = 9;
      endcase
      for (int n = 0; n < 40; n++) random_cmd();
      set_window(ph == 5 ? ott_pkg::DEFAULT_WINDOW : 32'($urandom_range(10000000)));
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
